>>> sv/kmr_pkg.sv
package kmr_pkg;

    localparam int REC_DEPTH_DEF    = 64;
    localparam int FRAME_EVENTS_DEF = 16;

    localparam int CODE_W     = 16;
    localparam int FRAME_W    = 32;
    localparam int KEYREG_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_REC  = 2'd1,
        MODE_PLAY = 2'd2
    } mode_t;

    localparam logic [1:0] SPEED_ONE   = 2'd0;
    localparam logic [1:0] SPEED_TRIM  = 2'd1;
    localparam logic [1:0] SPEED_FAST  = 2'd2;
    localparam logic [1:0] SPEED_SPARE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_KEY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYBACK_KEY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_KEY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ENABLE = 3'd5;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              ext;
        logic              rel;
    } key_ev_t;

    typedef struct packed {
        key_ev_t            ev;
        logic [FRAME_W-1:0] frame;
    } rec_ent_t;

    typedef struct packed {
        logic [KEYREG_W-1:0] record_key;
        logic [KEYREG_W-1:0] playback_key;
        logic [KEYREG_W-1:0] stop_key;
        logic [1:0]          speed_mode;
        logic                loop_enable;
        logic                block_enable;
    } cfg_t;

    typedef struct packed {
        logic rec;
        logic play;
        logic stop;
    } key_hit_t;

endpackage

>>> sv/kmr_in_if.sv
interface kmr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [kmr_pkg::CODE_W-1:0]    key_code;
    logic                          key_extended;
    logic                          key_release;

    modport source (output valid, kind, key_code, key_extended, key_release, input ready);
    modport sink   (input valid, kind, key_code, key_extended, key_release, output ready);
endinterface

>>> sv/kmr_out_if.sv
interface kmr_out_if;
    logic                          valid;
    logic                          ready;
    logic [kmr_pkg::CODE_W-1:0]    out_code;
    logic                          out_extended;
    logic                          out_release;
    logic                          last;
    logic [1:0]                    mode_now;

    modport source (output valid, out_code, out_extended, out_release, last, mode_now,
                    input ready);
    modport sink   (input valid, out_code, out_extended, out_release, last, mode_now,
                    output ready);
endinterface

>>> sv/kmr_cfg_if.sv
interface kmr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [kmr_pkg::CFG_IDX_W-1:0]   index;
    logic [kmr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/kmr_cfg_regs.sv
module kmr_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    kmr_cfg_if.sink       cfg,
    output kmr_pkg::cfg_t cfg_values
);
    import kmr_pkg::*;

    cfg_t cfg_reg;

    assign cfg.ready  = 1'b1;
    assign cfg_values = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.record_key   <= KEYREG_W'(59);
            cfg_reg.playback_key <= KEYREG_W'(60);
            cfg_reg.stop_key     <= KEYREG_W'(61);
            cfg_reg.speed_mode   <= SPEED_ONE;
            cfg_reg.loop_enable  <= 1'b0;
            cfg_reg.block_enable <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_RECORD_KEY:   cfg_reg.record_key   <= cfg.data[KEYREG_W-1:0];
                CFG_PLAYBACK_KEY: cfg_reg.playback_key <= cfg.data[KEYREG_W-1:0];
                CFG_STOP_KEY:     cfg_reg.stop_key     <= cfg.data[KEYREG_W-1:0];
                CFG_SPEED_MODE:   cfg_reg.speed_mode   <= cfg.data[1:0];
                CFG_LOOP_ENABLE:  cfg_reg.loop_enable  <= cfg.data[0];
                CFG_BLOCK_ENABLE: cfg_reg.block_enable <= cfg.data[0];
                default:          ;
            endcase
        end
    end
endmodule

>>> sv/kmr_key_match.sv
module kmr_key_match (
    input  kmr_pkg::key_ev_t  ev,
    input  kmr_pkg::cfg_t     cfg_values,
    output kmr_pkg::key_hit_t hit
);
    import kmr_pkg::*;

    logic [KEYREG_W-1:0] ev_key;

    // Register layout: extended flag above the scancode
    assign ev_key   = {ev.ext, ev.code};
    assign hit.rec  = (ev_key == cfg_values.record_key);
    assign hit.play = (ev_key == cfg_values.playback_key);
    assign hit.stop = (ev_key == cfg_values.stop_key);
endmodule

>>> sv/kmr_res_buf.sv
module kmr_res_buf #(
    parameter  int DEPTH = kmr_pkg::REC_DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  kmr_pkg::key_ev_t wr_data,
    input  logic [AW-1:0]    rd_addr,
    input  logic             push,
    input  logic             push_last,
    input  kmr_pkg::mode_t   push_mode,
    output logic             free,
    kmr_out_if.source        res
);
    import kmr_pkg::*;

    key_ev_t mem [DEPTH];
    key_ev_t rd_reg;
    logic    valid_reg;
    key_ev_t ev_reg;
    logic    last_reg;
    mode_t   mode_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign free = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ev_reg   <= rd_reg;
            last_reg <= push_last;
            mode_reg <= push_mode;
        end
    end

    assign res.valid        = valid_reg;
    assign res.out_code     = ev_reg.code;
    assign res.out_extended = ev_reg.ext;
    assign res.out_release  = ev_reg.rel;
    assign res.last         = last_reg;
    assign res.mode_now     = 2'(mode_reg);
endmodule

>>> sv/key_macro_record_playback_unit.sv
// Channel   Dir  Payload                                              Handshake
// key_in    in   kind, key_code, key_extended, key_release           valid/ready
// key_out   out  out_code, out_extended, out_release, last, mode_now valid/ready
// cfg       in   index, data                                          valid/ready
//
// A key event word is buffered in S_IDLE. A frame tick scans the buffered
// events for control-key presses at one compare a cycle, decides, runs the
// recording pass or walks the store on release or playback (registered store
// read per entry), finishes, and drains each result through a read state and an
// output state, waiting on any output stall.
// The block takes no word while a tick is at work; results leave through one
// output register, so the next word is taken while the last result waits.
// Reset: asynchronous, active low; clears mode and counters, restores config
// defaults; no sweep.
module key_macro_record_playback_unit #(
    parameter int REC_DEPTH    = kmr_pkg::REC_DEPTH_DEF,
    parameter int FRAME_EVENTS = kmr_pkg::FRAME_EVENTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    kmr_in_if.sink     key_in,
    kmr_out_if.source  key_out,
    kmr_cfg_if.sink    cfg
);
    import kmr_pkg::*;

    localparam int RC_W = $clog2(REC_DEPTH + 1);
    localparam int RA_W = (REC_DEPTH > 1) ? $clog2(REC_DEPTH) : 1;
    localparam int FC_W = $clog2(FRAME_EVENTS + 1);
    localparam int FA_W = (FRAME_EVENTS > 1) ? $clog2(FRAME_EVENTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RECORD,
        S_REL_RD,
        S_REL_CHK,
        S_PLAY_RD,
        S_PLAY_CHK,
        S_FIN,
        S_DRAIN_RD,
        S_DRAIN_OUT
    } state_t;

    state_t             state_reg,      state_next;
    mode_t              mode_reg,       mode_next;
    logic [FRAME_W-1:0] frame_cnt_reg,  frame_cnt_next;
    logic [RC_W-1:0]    play_idx_reg,   play_idx_next;
    logic [RC_W-1:0]    rec_count_reg,  rec_count_next;
    logic [FC_W-1:0]    fe_cnt_reg,     fe_cnt_next;
    logic [FC_W-1:0]    scan_idx_reg,   scan_idx_next;
    key_hit_t           pressed_reg,    pressed_next;
    logic [RC_W-1:0]    walk_idx_reg,   walk_idx_next;
    logic [RC_W-1:0]    res_cnt_reg,    res_cnt_next;

    cfg_t               cfg_values;
    key_hit_t           hit;
    key_ev_t            fe_mem [FRAME_EVENTS];
    key_ev_t            fe_rd;
    rec_ent_t           rec_mem [REC_DEPTH];
    rec_ent_t           st_rd_reg;
    logic [RA_W-1:0]    st_ra;
    logic               fe_we;
    logic               st_we;
    logic               res_we;
    key_ev_t            res_wd;
    logic               push;
    logic               push_last;
    logic               out_free;
    logic [FRAME_W-1:0] fc_eff;

    kmr_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_values (cfg_values)
    );

    // Shared compare unit: one buffered event against the three control keys
    assign fe_rd = fe_mem[scan_idx_reg[FA_W-1:0]];

    kmr_key_match u_match (
        .ev         (fe_rd),
        .cfg_values (cfg_values),
        .hit        (hit)
    );

    kmr_res_buf #(
        .DEPTH (REC_DEPTH)
    ) u_res (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (res_we),
        .wr_addr   (res_cnt_reg[RA_W-1:0]),
        .wr_data   (res_wd),
        .rd_addr   (walk_idx_reg[RA_W-1:0]),
        .push      (push),
        .push_last (push_last),
        .push_mode (mode_reg),
        .free      (out_free),
        .res       (key_out)
    );

    assign key_in.ready = (state_reg == S_IDLE);
    assign push_last    = (walk_idx_reg == (res_cnt_reg - RC_W'(1)));

    // Frame event buffer: append while room is left, drop beyond
    always_ff @(posedge clk)
    begin
        if (fe_we)
        begin
            fe_mem[fe_cnt_reg[FA_W-1:0]] <= '{code: key_in.key_code,
                                              ext:  key_in.key_extended,
                                              rel:  key_in.key_release};
        end
    end

    // Recording store: one write port at the fill count, one registered read
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            rec_mem[rec_count_reg[RA_W-1:0]] <= '{ev: fe_rd, frame: frame_cnt_reg};
        end
        st_rd_reg <= rec_mem[st_ra];
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        frame_cnt_next = frame_cnt_reg;
        play_idx_next  = play_idx_reg;
        rec_count_next = rec_count_reg;
        fe_cnt_next    = fe_cnt_reg;
        scan_idx_next  = scan_idx_reg;
        pressed_next   = pressed_reg;
        walk_idx_next  = walk_idx_reg;
        res_cnt_next   = res_cnt_reg;
        fe_we          = 1'b0;
        st_we          = 1'b0;
        res_we         = 1'b0;
        res_wd         = st_rd_reg.ev;
        st_ra          = play_idx_reg[RA_W-1:0];
        push           = 1'b0;
        fc_eff         = frame_cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (key_in.valid)
                begin
                    if (!key_in.kind)
                    begin
                        // Buffer the event for this frame
                        if (fe_cnt_reg < FC_W'(FRAME_EVENTS))
                        begin
                            fe_we       = 1'b1;
                            fe_cnt_next = fe_cnt_reg + FC_W'(1);
                        end
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        pressed_next  = '0;
                        res_cnt_next  = '0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Collect control-key presses; releases never count
                if (scan_idx_reg == fe_cnt_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    if (!fe_rd.rel)
                    begin
                        pressed_next = pressed_reg | hit;
                    end
                    scan_idx_next = scan_idx_reg + FC_W'(1);
                end
            end

            S_DECIDE:
            begin
                state_next = S_FIN;
                unique case (mode_reg)
                    MODE_OFF:
                    begin
                        if (cfg_values.block_enable)
                        begin
                            if (pressed_reg.rec)
                            begin
                                mode_next      = MODE_REC;
                                frame_cnt_next = '0;
                                rec_count_next = '0;
                            end
                            if (pressed_reg.play)
                            begin
                                mode_next      = MODE_PLAY;
                                frame_cnt_next = '0;
                                play_idx_next  = '0;
                            end
                        end
                    end
                    MODE_REC:
                    begin
                        if (pressed_reg.rec)
                        begin
                            mode_next = MODE_OFF;
                        end
                        else if (pressed_reg.play)
                        begin
                            mode_next      = MODE_PLAY;
                            frame_cnt_next = '0;
                            play_idx_next  = '0;
                        end
                        else
                        begin
                            scan_idx_next = '0;
                            state_next    = S_RECORD;
                        end
                    end
                    MODE_PLAY:
                    begin
                        if (!cfg_values.block_enable)
                        begin
                            mode_next = MODE_OFF;
                        end
                        else if (pressed_reg.rec || pressed_reg.play || pressed_reg.stop)
                        begin
                            walk_idx_next = '0;
                            state_next    = S_REL_RD;
                        end
                        else
                        begin
                            state_next = S_PLAY_RD;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_OFF;
                    end
                endcase
            end

            S_RECORD:
            begin
                // Store events stamped with the frame; skip the record and playback keys
                if (scan_idx_reg == fe_cnt_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    if (!(hit.rec || hit.play) && (rec_count_reg < RC_W'(REC_DEPTH)))
                    begin
                        st_we          = 1'b1;
                        rec_count_next = rec_count_reg + RC_W'(1);
                    end
                    scan_idx_next = scan_idx_reg + FC_W'(1);
                end
            end

            S_REL_RD:
            begin
                st_ra = walk_idx_reg[RA_W-1:0];
                if (walk_idx_reg == play_idx_reg)
                begin
                    // All played presses released: apply the cancel action
                    state_next = S_FIN;
                    if (pressed_reg.rec)
                    begin
                        mode_next      = MODE_REC;
                        frame_cnt_next = '0;
                        rec_count_next = '0;
                    end
                    else
                    begin
                        mode_next      = pressed_reg.play ? MODE_PLAY : MODE_OFF;
                        frame_cnt_next = '0;
                        play_idx_next  = '0;
                    end
                end
                else
                begin
                    state_next = S_REL_CHK;
                end
            end

            S_REL_CHK:
            begin
                if (!st_rd_reg.ev.rel)
                begin
                    res_we       = 1'b1;
                    res_wd       = '{code: st_rd_reg.ev.code, ext: st_rd_reg.ev.ext,
                                     rel: 1'b1};
                    res_cnt_next = res_cnt_reg + RC_W'(1);
                end
                walk_idx_next = walk_idx_reg + RC_W'(1);
                state_next    = S_REL_RD;
            end

            S_PLAY_RD:
            begin
                if (play_idx_reg >= rec_count_reg)
                begin
                    // End of recording: loop or drop to idle
                    state_next = S_FIN;
                    if (cfg_values.loop_enable)
                    begin
                        play_idx_next  = '0;
                        frame_cnt_next = '0;
                    end
                    else
                    begin
                        mode_next = MODE_OFF;
                    end
                end
                else
                begin
                    state_next = S_PLAY_CHK;
                end
            end

            S_PLAY_CHK:
            begin
                // Trim: jump to the first event's frame
                if ((play_idx_reg == '0) && (cfg_values.speed_mode == SPEED_TRIM))
                begin
                    fc_eff = st_rd_reg.frame;
                end
                frame_cnt_next = fc_eff;
                if (cfg_values.speed_mode == SPEED_FAST)
                begin
                    res_we        = 1'b1;
                    res_cnt_next  = res_cnt_reg + RC_W'(1);
                    play_idx_next = play_idx_reg + RC_W'(1);
                    state_next    = S_FIN;
                end
                else if (st_rd_reg.frame > fc_eff)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    res_we        = 1'b1;
                    res_cnt_next  = res_cnt_reg + RC_W'(1);
                    play_idx_next = play_idx_reg + RC_W'(1);
                    state_next    = S_PLAY_RD;
                end
            end

            S_FIN:
            begin
                frame_cnt_next = frame_cnt_reg + FRAME_W'(1);
                fe_cnt_next    = '0;
                walk_idx_next  = '0;
                state_next     = (res_cnt_reg == '0) ? S_IDLE : S_DRAIN_RD;
            end

            S_DRAIN_RD:
            begin
                state_next = S_DRAIN_OUT;
            end

            S_DRAIN_OUT:
            begin
                // Hand results out once mode after the tick is known
                if (out_free)
                begin
                    push          = 1'b1;
                    walk_idx_next = walk_idx_reg + RC_W'(1);
                    state_next    = push_last ? S_IDLE : S_DRAIN_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_OFF;
            frame_cnt_reg <= '0;
            play_idx_reg  <= '0;
            rec_count_reg <= '0;
            fe_cnt_reg    <= '0;
            scan_idx_reg  <= '0;
            pressed_reg   <= '0;
            walk_idx_reg  <= '0;
            res_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            frame_cnt_reg <= frame_cnt_next;
            play_idx_reg  <= play_idx_next;
            rec_count_reg <= rec_count_next;
            fe_cnt_reg    <= fe_cnt_next;
            scan_idx_reg  <= scan_idx_next;
            pressed_reg   <= pressed_next;
            walk_idx_reg  <= walk_idx_next;
            res_cnt_reg   <= res_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_rec_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rec_count_reg <= RC_W'(REC_DEPTH))
        else $error("recording count past store depth");

    a_play_within_rec: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_PLAY) |-> (play_idx_reg <= rec_count_reg))
        else $error("play index beyond recorded count");

    a_fe_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fe_cnt_reg <= FC_W'(FRAME_EVENTS))
        else $error("frame buffer count past depth");

    a_push_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (out_free && (state_reg == S_DRAIN_OUT)))
        else $error("result pushed into a busy output stage");
`endif
endmodule

>>> tb/tb_key_macro_record_playback_unit.sv
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the recorder state, predicts the key words
// that each frame tick injects and checks the output words against them in order.
class key_macro_scoreboard;
    typedef struct {
        bit [15:0]   code;
        bit          ext;
        bit          rel;
        int unsigned frame;
    } key_word_t;

    typedef struct {
        bit [15:0] code;
        bit        ext;
        bit        rel;
        bit        last;
        bit [1:0]  mode;
    } inject_t;

    localparam int STORE_DEPTH = kmr_pkg::REC_DEPTH_DEF;
    localparam int FRAME_DEPTH = kmr_pkg::FRAME_EVENTS_DEF;
    localparam int MAX_INJECT  = 64;

    bit [16:0]       rec_key, play_key, stop_key;
    bit [1:0]        speed;
    bit              loop_on, enable_on;
    kmr_pkg::mode_t  mode;
    int unsigned     frame_cnt, play_idx, rec_cnt, buf_cnt;
    key_word_t       store[STORE_DEPTH];
    key_word_t       frame_buf[FRAME_DEPTH];
    inject_t         injections[$];
    inject_t         pending_q[$];
    int              errors, results_seen, ticks_seen, injects_on_cancel;

    function new();
        rec_key = 17'd59; play_key = 17'd60; stop_key = 17'd61;
        speed = kmr_pkg::SPEED_ONE; loop_on = 1'b0; enable_on = 1'b1;
        mode = kmr_pkg::MODE_OFF;
        frame_cnt = 0; play_idx = 0; rec_cnt = 0; buf_cnt = 0;
        errors = 0; results_seen = 0; ticks_seen = 0; injects_on_cancel = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [16:0] val);
        case (idx)
            kmr_pkg::CFG_RECORD_KEY:   rec_key   = val;
            kmr_pkg::CFG_PLAYBACK_KEY: play_key  = val;
            kmr_pkg::CFG_STOP_KEY:     stop_key  = val;
            kmr_pkg::CFG_SPEED_MODE:   speed     = val[1:0];
            kmr_pkg::CFG_LOOP_ENABLE:  loop_on   = val[0];
            kmr_pkg::CFG_BLOCK_ENABLE: enable_on = val[0];
            default: ;
        endcase
    endfunction

    function bit matches_key(key_word_t k, bit [16:0] r);
        return k.code == r[15:0] && k.ext == r[16];
    endfunction

    function bit key_pressed(bit [16:0] r);
        for (int i = 0; i < buf_cnt; i++)
            if (!frame_buf[i].rel && matches_key(frame_buf[i], r))
                return 1'b1;
        return 1'b0;
    endfunction

    function void inject(bit [15:0] code, bit ext, bit rel);
        inject_t w;
        if (injections.size() >= MAX_INJECT)
            return;
        w.code = code; w.ext = ext; w.rel = rel; w.last = 1'b0; w.mode = kmr_pkg::MODE_OFF;
        injections.insert(injections.size(), w);
    endfunction

    // release every press already replayed, so no key stays stuck down
    function void release_held();
        for (int i = 0; i < play_idx && i < STORE_DEPTH; i++)
            if (!store[i].rel)
            begin
                inject(store[i].code, store[i].ext, 1'b1);
                injects_on_cancel++;
            end
    endfunction

    function void store_frame();
        for (int i = 0; i < buf_cnt; i++)
        begin
            if (matches_key(frame_buf[i], rec_key) || matches_key(frame_buf[i], play_key))
                continue;
            if (rec_cnt >= STORE_DEPTH)
                continue;
            store[rec_cnt] = frame_buf[i];
            store[rec_cnt].frame = frame_cnt;
            rec_cnt++;
        end
    endfunction

    function void replay_step();
        while (play_idx < rec_cnt)
        begin
            if (play_idx == 0 && speed == kmr_pkg::SPEED_TRIM)
                frame_cnt = store[0].frame;
            if (speed == kmr_pkg::SPEED_FAST)
            begin
                inject(store[play_idx].code, store[play_idx].ext, store[play_idx].rel);
                play_idx++;
                return;
            end
            if (store[play_idx].frame > frame_cnt)
                return;
            inject(store[play_idx].code, store[play_idx].ext, store[play_idx].rel);
            play_idx++;
        end
        if (loop_on)
        begin
            play_idx = 0;
            frame_cnt = 0;
        end
        else
            mode = kmr_pkg::MODE_OFF;
    endfunction

    function void note_word(bit kind, bit [15:0] code, bit ext, bit rel);
        injections.delete();
        if (!kind)
        begin
            // events past the frame buffer depth are dropped
            if (buf_cnt < FRAME_DEPTH)
            begin
                frame_buf[buf_cnt].code = code;
                frame_buf[buf_cnt].ext = ext;
                frame_buf[buf_cnt].rel = rel;
                frame_buf[buf_cnt].frame = 0;
                buf_cnt++;
            end
            return;
        end
        ticks_seen++;
        case (mode)
            kmr_pkg::MODE_OFF:
            begin
                if (enable_on)
                begin
                    if (key_pressed(rec_key))
                    begin
                        mode = kmr_pkg::MODE_REC; frame_cnt = 0; rec_cnt = 0;
                    end
                    if (key_pressed(play_key))
                    begin
                        mode = kmr_pkg::MODE_PLAY; frame_cnt = 0; play_idx = 0;
                    end
                end
            end
            kmr_pkg::MODE_REC:
            begin
                if (key_pressed(rec_key))
                    mode = kmr_pkg::MODE_OFF;
                else if (key_pressed(play_key))
                begin
                    mode = kmr_pkg::MODE_PLAY; frame_cnt = 0; play_idx = 0;
                end
                else
                    store_frame();
            end
            kmr_pkg::MODE_PLAY:
            begin
                if (!enable_on)
                    mode = kmr_pkg::MODE_OFF;
                else if (key_pressed(rec_key))
                begin
                    release_held();
                    mode = kmr_pkg::MODE_REC; frame_cnt = 0; rec_cnt = 0;
                end
                else if (key_pressed(play_key))
                begin
                    release_held();
                    mode = kmr_pkg::MODE_PLAY; frame_cnt = 0; play_idx = 0;
                end
                else if (key_pressed(stop_key))
                begin
                    release_held();
                    mode = kmr_pkg::MODE_OFF; frame_cnt = 0; play_idx = 0;
                end
                else
                    replay_step();
            end
            default: mode = kmr_pkg::MODE_OFF;
        endcase
        frame_cnt++;
        buf_cnt = 0;
        foreach (injections[i])
        begin
            injections[i].last = (i == injections.size() - 1);
            injections[i].mode = mode;
            pending_q.insert(pending_q.size(), injections[i]);
        end
    endfunction

    function void check_word(bit [15:0] code, bit ext, bit rel, bit last, bit [1:0] m);
        inject_t e;
        results_seen++;
        if (pending_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: unexpected word code=%h ext=%0b rel=%0b last=%0b mode=%0d",
                         $realtime, code, ext, rel, last, m);
            return;
        end
        e = pending_q.pop_front();
        if (e.code !== code || e.ext !== ext || e.rel !== rel || e.last !== last
            || e.mode !== m)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("%0t: mismatch exp code=%h ext=%0b rel=%0b last=%0b mode=%0d,",
                         $realtime, e.code, e.ext, e.rel, e.last, e.mode);
                $display("    got code=%h ext=%0b rel=%0b last=%0b mode=%0d",
                         code, ext, rel, last, m);
            end
        end
    endfunction

    function int pending();
        return pending_q.size();
    endfunction
endclass

module tb_key_macro_record_playback_unit;
    import kmr_pkg::*;

    localparam int SETTLE_CYCLES = 600;    // well past the longest tick that injects nothing
    localparam int STALL_LIMIT   = 6000;   // cycles without any handshake

    logic clk;
    logic rst_n;

    kmr_in_if  key_in ();
    kmr_out_if key_out ();
    kmr_cfg_if cfg ();

    key_macro_record_playback_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_in  (key_in),
        .key_out (key_out),
        .cfg     (cfg)
    );

    key_macro_scoreboard sb;
    int  words_sent;
    int  hold_cycles;       // long receiver hold-off, counted down by the receiver
    bit  no_gaps;           // stretch with no idling on either side
    int  quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        key_in.valid = 1'b0;
        key_in.kind = 1'b0;
        key_in.key_code = '0;
        key_in.key_extended = 1'b0;
        key_in.key_release = 1'b0;
        key_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        words_sent = 0;
        hold_cycles = 0;
        no_gaps = 1'b0;
        quiet_cycles = 0;
    end

    // Pick an idle gap: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                key_out.ready <= 1'b0;
                hold_cycles--;
            end
            else if (gap > 0)
            begin
                key_out.ready <= 1'b0;
                gap--;
            end
            else
            begin
                key_out.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    gap = pick_gap();
            end
        end
    end

    // Sample at the falling edge: inputs and outputs are settled for the next
    // rising edge, where the handshake happens.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (key_out.valid && key_out.ready)
                sb.check_word(key_out.out_code, key_out.out_extended, key_out.out_release,
                              key_out.last, key_out.mode_now);
            if ((key_out.valid && key_out.ready) || (key_in.valid && key_in.ready)
                || (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer one word, hold it until taken, and note it for the predictor.
    task automatic send_word(bit kind, bit [15:0] code, bit ext, bit rel);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            key_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_in.valid <= 1'b1;
        key_in.kind <= kind;
        key_in.key_code <= code;
        key_in.key_extended <= ext;
        key_in.key_release <= rel;
        forever
        begin
            @(negedge clk);
            if (key_in.ready)
                break;
        end
        sb.note_word(kind, code, ext, rel);
        words_sent++;
        @(posedge clk);
    endtask

    task automatic send_event(bit [15:0] code, bit ext, bit rel);
        send_word(1'b0, code, ext, rel);
    endtask

    task automatic send_tick();
        send_word(1'b1, 16'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic press_key(bit [16:0] k);
        send_event(k[15:0], k[16], 1'b0);
    endtask

    // Drain every expected word, then let the block finish any silent work.
    task automatic settle();
        key_in.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hold one register write until taken; the caller drops valid after the last.
    task automatic write_reg(bit [2:0] idx, bit [16:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        forever
        begin
            @(negedge clk);
            if (cfg.ready)
                break;
        end
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic setup(bit [16:0] rk, bit [16:0] pk, bit [16:0] sk,
                         bit [1:0] spd, bit lp, bit en);
        settle();
        write_reg(CFG_RECORD_KEY, rk);
        write_reg(CFG_PLAYBACK_KEY, pk);
        write_reg(CFG_STOP_KEY, sk);
        write_reg(CFG_SPEED_MODE, 17'(spd));
        write_reg(CFG_LOOP_ENABLE, 17'(lp));
        write_reg(CFG_BLOCK_ENABLE, 17'(en));
        cfg.valid <= 1'b0;
    endtask

    // One frame of noise: random keys, sometimes a control key, sometimes
    // more events than the frame buffer holds.
    task automatic noise_frame();
        int n;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 19) : $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: send_event(sb.rec_key[15:0], sb.rec_key[16], $urandom_range(0, 3) == 0);
                1: send_event(sb.play_key[15:0], sb.play_key[16], $urandom_range(0, 3) == 0);
                2: send_event(sb.stop_key[15:0], sb.stop_key[16], $urandom_range(0, 3) == 0);
                default: send_event(16'($urandom), 1'($urandom), 1'($urandom));
            endcase
        end
        send_tick();
    endtask

    // A recording session followed by playback, with random content and an
    // occasional cancel in the middle.
    task automatic macro_session();
        int frames;
        int n;
        press_key(sb.rec_key);
        send_tick();
        frames = $urandom_range(1, 6);
        for (int f = 0; f < frames; f++)
        begin
            n = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                send_event(16'($urandom), 1'($urandom), 1'($urandom));
            if ($urandom_range(0, 5) == 0)
                send_event(sb.play_key[15:0], sb.play_key[16], 1'b1);
            send_tick();
        end
        // leave recording by the record key or go straight to playback
        if ($urandom_range(0, 1))
        begin
            press_key(sb.rec_key);
            send_tick();
        end
        press_key(sb.play_key);
        send_tick();
        for (int t = 0; t < 14 && sb.mode == MODE_PLAY; t++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: press_key(sb.stop_key);
                    1: press_key(sb.play_key);
                    default: press_key(sb.rec_key);
                endcase
            end
            send_tick();
        end
        if (sb.mode != MODE_OFF)
        begin
            if (sb.mode == MODE_PLAY)
                press_key(sb.stop_key);
            else
                press_key(sb.rec_key);
            send_tick();
        end
    endtask

    task automatic random_run(int words);
        int target;
        target = words_sent + words;
        while (words_sent < target)
        begin
            if ($urandom_range(0, 3) == 0)
                noise_frame();
            else
                macro_session();
        end
    endtask

    initial
    begin
        @(posedge clk);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, filtered control keys, record, stop, playback, cancel.
        no_gaps = 1'b1;
        send_event(16'h0000, 1'b0, 1'b0);
        send_event(16'hFFFF, 1'b1, 1'b1);
        send_tick();                                 // idle, nothing happens
        press_key(sb.rec_key);
        send_tick();                                 // start recording
        send_event(16'hFFFF, 1'b1, 1'b0);
        send_event(16'h0000, 1'b0, 1'b0);
        send_event(sb.rec_key[15:0], sb.rec_key[16], 1'b1);   // filtered out
        send_tick();
        send_event(16'hFFFF, 1'b1, 1'b1);
        send_tick();
        send_tick();
        press_key(sb.rec_key);
        send_tick();                                 // stop recording
        press_key(sb.play_key);
        send_tick();                                 // start playback
        send_tick();
        press_key(sb.stop_key);
        send_tick();                                 // cancel: release stuck keys
        press_key(sb.rec_key);
        press_key(sb.play_key);
        send_tick();                                 // both keys in one tick
        send_tick();
        send_tick();
        no_gaps = 1'b0;

        random_run(50);

        // Trim startup with looping; hold the receiver off to fill the block.
        setup(17'd59, 17'd60, 17'd61, SPEED_TRIM, 1'b1, 1'b1);
        hold_cycles = 500;
        random_run(60);

        // Fast mode with the key registers at their extremes.
        setup(17'd0, 17'h1FFFF, 17'h10000, SPEED_FAST, 1'b0, 1'b1);
        no_gaps = 1'b1;
        random_run(30);
        no_gaps = 1'b0;
        random_run(30);

        // The undefined speed code, first with the control keys locked out, then enabled.
        setup(17'd59, 17'd60, 17'd61, SPEED_SPARE, 1'b0, 1'b0);
        random_run(25);
        setup(17'd59, 17'd60, 17'd61, SPEED_SPARE, 1'b1, 1'b1);
        random_run(35);

        // One to one with looping and random keys.
        setup(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)),
              17'($urandom_range(0, 131071)), SPEED_ONE, 1'b1, 1'b1);
        random_run(60);

        settle();
        $display("Covered %0d input words, %0d frame ticks, %0d injected words checked",
                 words_sent, sb.ticks_seen, sb.results_seen);
        $display("%0d releases injected on cancel, %0d mismatches",
                 sb.injects_on_cancel, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
